// ----- rtl/matrix_multiply_row_col_sums_assert.svh -----
// assertion macros for the matrix multiplier
`ifndef MATRIX_MULTIPLY_ROW_COL_SUMS_ASSERT_SVH
`define MATRIX_MULTIPLY_ROW_COL_SUMS_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define MM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition that must hold on every rising clock edge outside reset
`define MM_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`endif

// ----- rtl/mmrcs_pkg.sv -----
// ----------------------------------------------------------------------------
// mmrcs_pkg
// types and constants shared by the matrix multiplier files
// ----------------------------------------------------------------------------
package mmrcs_pkg;

  localparam int MAX_DIM_DEF   = 16;
  localparam int ELEM_BITS_DEF = 16;
  localparam int CFG_W         = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int VALUE_W       = 40;
  localparam int PROD_W        = 36;

  localparam logic [2:0] FUNC_WR_A  = 3'd0;
  localparam logic [2:0] FUNC_WR_B  = 3'd1;
  localparam logic [2:0] FUNC_COMP  = 3'd2;
  localparam logic [2:0] FUNC_RD_P  = 3'd3;
  localparam logic [2:0] FUNC_RD_RS = 3'd4;
  localparam logic [2:0] FUNC_RD_CS = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [15:0] element;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [1:0]                status;
  } out_item_t;

endpackage

// ----- rtl/mmrcs_ram.sv -----
// ----------------------------------------------------------------------------
// mmrcs_ram
// single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
module mmrcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/matrix_multiply_row_col_sums.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_row_col_sums
// integer matrix multiplier with product row and column sums
// ----------------------------------------------------------------------------
// Items arrive on the in_ valid/ready channel, one result per item leaves on
// the out_ valid/ready channel. Sizes are set on the cfg_ write port; the user
// must write them only while the block is idle, which the block itself does
// not enforce. One item is handled at a time. Writes of A or B and reads pass
// the item register, the ram read state and then the result register; the
// next item is taken only after the previous result has been transferred.
// A compute with matching inner sizes first runs the clearing pass, then
// walks every product element: per element, cols_a multiply accumulate
// steps (address, ram read, registered multiply, accumulate), then the
// store, column sum read and column sum write states that store the product
// and read-modify-write the column sum ram, and S_OUT raises result valid.
// After reset a clearing pass over every product ram address zeroes the
// product and sum rams; no input is taken meanwhile.
// When the receiver stalls the result is held in the output register and no
// new input is taken until it is transferred.
// ----------------------------------------------------------------------------
module matrix_multiply_row_col_sums #(
  parameter int MAX_DIM   = mmrcs_pkg::MAX_DIM_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  mmrcs_pkg::in_item_t                        in_data,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output mmrcs_pkg::out_item_t                       out_data,
  input  logic                                       cfg_we,
  input  logic [mmrcs_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [mmrcs_pkg::CFG_W-1:0]                cfg_wdata
);
  import mmrcs_pkg::*;
  `include "matrix_multiply_row_col_sums_assert.svh"

  localparam int ELEM_BITS = ELEM_BITS_DEF;
  localparam int DW  = $clog2(MAX_DIM) > 0 ? $clog2(MAX_DIM) : 1;
  localparam int AW  = 2 * DW;
  localparam int DEP = 1 << AW;
  localparam int CW  = DW + 1;
  localparam int PW  = (2 * ELEM_BITS + DW + 1 < VALUE_W) ? 2 * ELEM_BITS + DW + 1 : VALUE_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_RESP, S_MAC_ISSUE, S_MAC_WAIT, S_MAC_MUL,
    S_MAC_ACC, S_STORE, S_CS_WAIT, S_CS_WR, S_OUT
  } state_t;

  state_t state_r;
  logic [CFG_W-1:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  in_item_t         item_r;
  out_item_t        out_r;
  logic             out_valid_r;
  logic             compute_pend_r;
  logic [AW-1:0]    clr_r;
  logic [DW-1:0]    i_r, k_r, j_r;
  logic             last_j_r;
  logic signed [2*ELEM_BITS-1:0] mul_r;
  logic signed [VALUE_W-1:0]     acc_r, rsum_r;

  // effective sizes
  logic [CW-1:0] ra, ca, rb, cb;
  function automatic logic [CW-1:0] eff(input logic [CFG_W-1:0] v);
    if (32'(v) > MAX_DIM) eff = CW'(MAX_DIM);
    else eff = CW'(v);
  endfunction
  assign ra = eff(rows_a_r);
  assign ca = eff(cols_a_r);
  assign rb = eff(rows_b_r);
  assign cb = eff(cols_b_r);

  // item field views
  logic [DW-1:0] r_i, c_i;
  assign r_i   = DW'(item_r.row_index);
  assign c_i   = DW'(item_r.col_index);
  logic row_ok_a, col_ok_a, row_ok_b, col_ok_b, col_ok_p;
  assign row_ok_a = 5'(item_r.row_index) < 5'(ra);
  assign col_ok_a = 5'(item_r.col_index) < 5'(ca);
  assign row_ok_b = 5'(item_r.row_index) < 5'(rb);
  assign col_ok_b = 5'(item_r.col_index) < 5'(cb);
  assign col_ok_p = col_ok_b;

  // rams
  logic                 a_we, b_we, p_we, rs_we, cs_we;
  logic [AW-1:0]        a_wa, b_wa, p_wa, a_ra, b_ra, p_ra;
  logic [DW-1:0]        rs_wa, cs_wa, rs_ra, cs_ra;
  logic [ELEM_BITS-1:0] a_rd, b_rd, elem_w;
  logic [PW-1:0]        p_wd, p_rd;
  logic [VALUE_W-1:0]   rs_wd, cs_wd, rs_rd, cs_rd;

  assign elem_w = item_r.element[ELEM_BITS-1:0];

  mmrcs_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEP)) u_ram_a (
    .clk, .we(a_we), .waddr(a_wa), .wdata(elem_w), .raddr(a_ra), .rdata(a_rd));
  mmrcs_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEP)) u_ram_b (
    .clk, .we(b_we), .waddr(b_wa), .wdata(elem_w), .raddr(b_ra), .rdata(b_rd));
  mmrcs_ram #(.WIDTH(PW), .DEPTH(DEP)) u_ram_p (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  mmrcs_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DIM)) u_ram_rs (
    .clk, .we(rs_we), .waddr(rs_wa), .wdata(rs_wd), .raddr(rs_ra), .rdata(rs_rd));
  mmrcs_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DIM)) u_ram_cs (
    .clk, .we(cs_we), .waddr(cs_wa), .wdata(cs_wd), .raddr(cs_ra), .rdata(cs_rd));

  logic clr_on;
  assign clr_on = (state_r == S_CLEAR);

  assign a_we = (state_r == S_RD) && item_r.func == FUNC_WR_A && row_ok_a && col_ok_a;
  assign b_we = (state_r == S_RD) && item_r.func == FUNC_WR_B && row_ok_b && col_ok_b;
  assign a_wa = {r_i, c_i};
  assign b_wa = {r_i, c_i};
  assign a_ra = {i_r, j_r};
  assign b_ra = {j_r, k_r};

  assign p_we  = clr_on || (state_r == S_STORE);
  assign p_wa  = clr_on ? clr_r : {i_r, k_r};
  assign p_wd  = clr_on ? '0 : acc_r[PW-1:0];
  assign p_ra  = {r_i, c_i};
  logic clr_sum;
  assign clr_sum = clr_on && (clr_r[AW-1:DW] == '0);
  assign rs_we = clr_sum || ((state_r == S_STORE) && 32'(k_r) == 32'(cb) - 1);
  assign rs_wa = clr_sum ? clr_r[DW-1:0] : i_r;
  assign rs_wd = clr_sum ? '0 : rsum_r + acc_r;
  assign rs_ra = r_i;
  assign cs_we = clr_sum || (state_r == S_CS_WR);
  assign cs_wa = clr_sum ? clr_r[DW-1:0] : k_r;
  assign cs_wd = clr_sum ? '0 : cs_rd + acc_r;
  assign cs_ra = (state_r == S_RD) ? c_i : k_r;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic [PW-1:0] p_sx;
  assign p_sx = p_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      rows_a_r       <= CFG_W'(1);
      cols_a_r       <= CFG_W'(1);
      rows_b_r       <= CFG_W'(1);
      cols_b_r       <= CFG_W'(1);
      out_valid_r    <= 1'b0;
      compute_pend_r <= 1'b0;
      clr_r          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS_A: rows_a_r <= cfg_wdata;
          REG_COLS_A: cols_a_r <= cfg_wdata;
          REG_ROWS_B: rows_b_r <= cfg_wdata;
          REG_COLS_B: cols_b_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) begin
            if (compute_pend_r) begin
              compute_pend_r <= 1'b0;
              if (ra == '0 || cb == '0) state_r <= S_OUT;
              else begin
                i_r <= '0; k_r <= '0; j_r <= '0;
                acc_r <= '0; rsum_r <= '0;
                state_r <= (ca == '0) ? S_STORE : S_MAC_ISSUE;
              end
            end else state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item_r  <= in_data;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          out_r.value  <= '0;
          out_r.status <= ST_OK;
          state_r      <= S_RESP;
          case (item_r.func)
            FUNC_WR_A: if (!(row_ok_a && col_ok_a)) out_r.status <= ST_RANGE;
            FUNC_WR_B: if (!(row_ok_b && col_ok_b)) out_r.status <= ST_RANGE;
            FUNC_COMP: begin
              if (ca != rb) out_r.status <= ST_MISMATCH;
              else begin
                compute_pend_r <= 1'b1;
                clr_r          <= '0;
                state_r        <= S_CLEAR;
              end
            end
            FUNC_RD_P: if (!(row_ok_a && col_ok_p)) out_r.status <= ST_RANGE;
            FUNC_RD_RS: if (!row_ok_a) out_r.status <= ST_RANGE;
            FUNC_RD_CS: if (!col_ok_b) out_r.status <= ST_RANGE;
            default: ;
          endcase
        end
        S_RESP: begin
          if (out_r.status == ST_OK) begin
            case (item_r.func)
              FUNC_RD_P:  out_r.value <= VALUE_W'(signed'(p_sx));
              FUNC_RD_RS: out_r.value <= rs_rd;
              FUNC_RD_CS: out_r.value <= cs_rd;
              default: ;
            endcase
          end
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_MAC_ISSUE: begin
          last_j_r <= 32'(j_r) == 32'(ca) - 1;
          state_r  <= S_MAC_WAIT;
        end
        S_MAC_WAIT: state_r <= S_MAC_MUL;
        S_MAC_MUL: begin
          mul_r   <= signed'(a_rd) * signed'(b_rd);
          state_r <= S_MAC_ACC;
        end
        S_MAC_ACC: begin
          acc_r <= acc_r + VALUE_W'(mul_r);
          if (last_j_r) state_r <= S_STORE;
          else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_MAC_ISSUE;
          end
        end
        S_STORE: begin
          rsum_r  <= (32'(k_r) == 32'(cb) - 1) ? '0 : rsum_r + acc_r;
          state_r <= S_CS_WAIT;
        end
        S_CS_WAIT: state_r <= S_CS_WR;
        S_CS_WR: begin
          acc_r <= '0;
          j_r   <= '0;
          if (32'(k_r) == 32'(cb) - 1) begin
            k_r <= '0;
            if (32'(i_r) == 32'(ra) - 1) state_r <= S_OUT;
            else begin
              i_r     <= i_r + 1'b1;
              state_r <= (ca == '0) ? S_STORE : S_MAC_ISSUE;
            end
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= (ca == '0) ? S_STORE : S_MAC_ISSUE;
          end
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `MM_ASSERT_IMP(a_no_accept_busy, state_r != S_IDLE, !in_ready)
  `MM_ASSERT_IMP(a_hold_stall, out_valid && !out_ready, ##1 out_valid && $stable(out_data))
  `MM_ASSERT_ALWAYS(a_one_write, !(a_we && b_we))
  `MM_ASSERT_IMP(a_clear_quiet, state_r == S_CLEAR, !out_valid_r || !in_ready)

endmodule

// ----- tb/tb_matrix_multiply_row_col_sums.sv -----
// ----------------------------------------------------------------------------
// tb_matrix_multiply_row_col_sums
// self-checking testbench for the integer matrix multiplier
// ----------------------------------------------------------------------------
// Loads A and B, runs computes and reads back product elements, row sums and
// column sums under several size settings, among them empty, oversized and
// mismatched ones. Each result is checked against an in-bench prediction of
// the stores, with random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_row_col_sums;
  timeunit 1ns;
  timeprecision 1ps;
  import mmrcs_pkg::*;

  localparam logic [2:0] FUNC_NOP6 = 3'd6;
  localparam logic [2:0] FUNC_NOP7 = 3'd7;
  localparam int IDLE_LIMIT = 100000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ROWS_A;
  logic [CFG_W-1:0] cfg_wdata = '0;

  matrix_multiply_row_col_sums dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted block state
  logic [4:0] sz_rows_a = 5'd1, sz_cols_a = 5'd1, sz_rows_b = 5'd1, sz_cols_b = 5'd1;
  logic signed [15:0] shadow_a [16][16];
  logic signed [15:0] shadow_b [16][16];
  logic [39:0] shadow_prod [16][16];
  logic [39:0] shadow_rsum [16];
  logic [39:0] shadow_csum [16];

  in_item_t host_ops[$];
  out_item_t pending_results[$];
  int n_in = 0, n_out = 0, n_fail = 0, n_comp = 0, n_mism = 0, n_range = 0;
  int idle_cnt = 0;
  bit in_fire = 1'b0;
  int hold_cnt = 0;
  bit held = 1'b0;

  function automatic int eff_dim(logic [4:0] v);
    return (v > 16) ? 16 : int'(v);
  endfunction

  function automatic out_item_t matmul_result(in_item_t it);
    out_item_t r;
    int ra, ca, rb, cb;
    longint acc, x, y;
    r.value = '0;
    r.status = ST_OK;
    ra = eff_dim(sz_rows_a);
    ca = eff_dim(sz_cols_a);
    rb = eff_dim(sz_rows_b);
    cb = eff_dim(sz_cols_b);
    case (it.func)
      FUNC_WR_A: begin
        if (it.row_index < ra && it.col_index < ca) shadow_a[it.row_index][it.col_index] = it.element;
        else r.status = ST_RANGE;
      end
      FUNC_WR_B: begin
        if (it.row_index < rb && it.col_index < cb) shadow_b[it.row_index][it.col_index] = it.element;
        else r.status = ST_RANGE;
      end
      FUNC_COMP: begin
        if (ca != rb) begin
          r.status = ST_MISMATCH;
        end else begin
          for (int i = 0; i < 16; i++) begin
            shadow_rsum[i] = '0;
            shadow_csum[i] = '0;
            for (int k = 0; k < 16; k++) shadow_prod[i][k] = '0;
          end
          for (int i = 0; i < ra; i++) begin
            for (int k = 0; k < cb; k++) begin
              acc = 0;
              for (int j = 0; j < ca; j++) begin
                x = shadow_a[i][j];
                y = shadow_b[j][k];
                acc += x * y;
              end
              shadow_prod[i][k] = acc[39:0];
              shadow_rsum[i] = shadow_rsum[i] + acc[39:0];
              shadow_csum[k] = shadow_csum[k] + acc[39:0];
            end
          end
        end
      end
      FUNC_RD_P: begin
        if (it.row_index < ra && it.col_index < cb) r.value = shadow_prod[it.row_index][it.col_index];
        else r.status = ST_RANGE;
      end
      FUNC_RD_RS: begin
        if (it.row_index < ra) r.value = shadow_rsum[it.row_index];
        else r.status = ST_RANGE;
      end
      FUNC_RD_CS: begin
        if (it.col_index < cb) r.value = shadow_csum[it.col_index];
        else r.status = ST_RANGE;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t make_op(logic [2:0] f, int r, int c, logic [15:0] e);
    in_item_t it;
    it.func = f;
    it.row_index = r[3:0];
    it.col_index = c[3:0];
    it.element = e;
    return it;
  endfunction

  function automatic int pick_below(int n);
    return (n == 0) ? int'($urandom_range(15)) : int'($urandom_range(n - 1));
  endfunction

  function automatic logic [15:0] pick_elem();
    int e;
    e = $urandom_range(7);
    return (e == 0) ? 16'h8000 : (e == 1) ? 16'h7fff : (e == 2) ? 16'h0000 : 16'($urandom);
  endfunction

  function automatic in_item_t random_op(int comp_pct);
    in_item_t it;
    int f;
    int ra, ca, rb, cb;
    ra = eff_dim(sz_rows_a);
    ca = eff_dim(sz_cols_a);
    rb = eff_dim(sz_rows_b);
    cb = eff_dim(sz_cols_b);
    if ($urandom_range(99) < 10) begin
      it = in_item_t'(27'($urandom));
      if (it.func == FUNC_COMP && $urandom_range(99) >= comp_pct) it.func = FUNC_RD_P;
      return it;
    end
    f = $urandom_range(99);
    if (f < comp_pct) return make_op(FUNC_COMP, 0, 0, pick_elem());
    f = $urandom_range(99);
    if (f < 25) return make_op(FUNC_WR_A, pick_below(ra), pick_below(ca), pick_elem());
    if (f < 50) return make_op(FUNC_WR_B, pick_below(rb), pick_below(cb), pick_elem());
    if (f < 78) return make_op(FUNC_RD_P, pick_below(ra), pick_below(cb), pick_elem());
    if (f < 89) return make_op(FUNC_RD_RS, pick_below(ra), $urandom_range(15), pick_elem());
    return make_op(FUNC_RD_CS, $urandom_range(15), pick_below(cb), pick_elem());
  endfunction

  // transfer detection, prediction, checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      in_fire = in_valid && in_ready;
      idle_cnt++;
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS_A: sz_rows_a = cfg_wdata;
          REG_COLS_A: sz_cols_a = cfg_wdata;
          REG_ROWS_B: sz_rows_b = cfg_wdata;
          REG_COLS_B: sz_cols_b = cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        pending_results.push_back(matmul_result(in_data));
        n_in++;
        idle_cnt = 0;
      end
      if (out_valid && out_ready) begin
        out_item_t exp_r;
        idle_cnt = 0;
        n_out++;
        if (out_data.status == ST_MISMATCH) n_mism++;
        if (out_data.status == ST_RANGE) n_range++;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: value %0d status %0d",
                 out_data.value, out_data.status);
          n_fail++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_data.value !== exp_r.value) begin
            $error("value: expected %0d, got %0d", exp_r.value, out_data.value);
            n_fail++;
          end
          if (out_data.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_data.status);
            n_fail++;
          end
        end
      end
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", idle_cnt);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      in_fire = 1'b0;
      if (host_ops.size() > 0 &&
          ((n_in > 700 && n_in < 1000) || $urandom_range(99) >= 20)) begin
        in_data <= host_ops.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!held && n_out >= 300) begin
        held = 1'b1;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (n_out > 700 && n_out < 1000) || ($urandom_range(99) >= 20);
      end
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (host_ops.size() > 0 || in_valid || pending_results.size() > 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_sizes(logic [4:0] ra, logic [4:0] ca, logic [4:0] rb, logic [4:0] cb);
    logic [4:0] v [4];
    v = '{ra, ca, rb, cb};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= v[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(logic [4:0] ra, logic [4:0] ca, logic [4:0] rb, logic [4:0] cb,
                              int n, int comp_pct);
    set_sizes(ra, ca, rb, cb);
    for (int i = 0; i < n; i++) host_ops.push_back(random_op(comp_pct));
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset sizes: cleared stores, range errors, unused selectors
    host_ops.push_back(make_op(FUNC_RD_P, 0, 0, 16'h0));
    host_ops.push_back(make_op(FUNC_RD_RS, 0, 9, 16'h0));
    host_ops.push_back(make_op(FUNC_RD_CS, 9, 0, 16'h0));
    host_ops.push_back(make_op(FUNC_RD_P, 1, 0, 16'h0));
    host_ops.push_back(make_op(FUNC_RD_P, 0, 15, 16'h0));
    host_ops.push_back(make_op(FUNC_RD_RS, 15, 0, 16'h0));
    host_ops.push_back(make_op(FUNC_RD_CS, 0, 15, 16'h0));
    host_ops.push_back(make_op(FUNC_NOP6, 15, 15, 16'hffff));
    host_ops.push_back(make_op(FUNC_NOP7, 0, 0, 16'h1234));
    host_ops.push_back(make_op(FUNC_WR_A, 0, 1, 16'h7fff));
    host_ops.push_back(make_op(FUNC_WR_B, 1, 0, 16'h8000));
    drain();

    // full-size load so that no unwritten element is ever used
    set_sizes(5'd16, 5'd16, 5'd16, 5'd16);
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++) begin
        host_ops.push_back(make_op(FUNC_WR_A, r, c, pick_elem()));
        host_ops.push_back(make_op(FUNC_WR_B, r, c, pick_elem()));
      end
    host_ops.push_back(make_op(FUNC_COMP, 0, 0, 16'h0));
    host_ops.push_back(make_op(FUNC_RD_P, 15, 15, 16'h0));
    host_ops.push_back(make_op(FUNC_RD_P, 0, 0, 16'h0));
    host_ops.push_back(make_op(FUNC_RD_RS, 15, 3, 16'h0));
    host_ops.push_back(make_op(FUNC_RD_CS, 3, 15, 16'h0));
    host_ops.push_back(make_op(FUNC_WR_A, 15, 15, 16'h8000));
    host_ops.push_back(make_op(FUNC_WR_B, 15, 15, 16'h8000));
    host_ops.push_back(make_op(FUNC_COMP, 0, 0, 16'h0));
    host_ops.push_back(make_op(FUNC_RD_RS, 15, 0, 16'h0));
    drain();

    // inner mismatch leaves the stores alone
    set_sizes(5'd16, 5'd3, 5'd4, 5'd16);
    host_ops.push_back(make_op(FUNC_COMP, 0, 0, 16'h0));
    host_ops.push_back(make_op(FUNC_RD_P, 15, 15, 16'h0));
    host_ops.push_back(make_op(FUNC_RD_CS, 0, 15, 16'h0));
    drain();

    random_phase(5'd3, 5'd3, 5'd3, 5'd3, 150, 6);
    random_phase(5'd2, 5'd5, 5'd5, 5'd1, 120, 6);
    random_phase(5'd1, 5'd1, 5'd1, 5'd1, 100, 8);
    random_phase(5'd4, 5'd2, 5'd3, 5'd4, 100, 8);
    random_phase(5'd0, 5'd2, 5'd2, 5'd3, 80, 8);
    random_phase(5'd5, 5'd0, 5'd0, 5'd5, 80, 8);
    random_phase(5'd31, 5'd31, 5'd20, 5'd17, 120, 3);
    random_phase(5'd2, 5'd16, 5'd16, 5'd2, 120, 6);
    random_phase(5'd7, 5'd4, 5'd4, 5'd6, 150, 5);
    for (int p = 0; p < 4; p++) begin
      logic [4:0] inner;
      inner = 5'($urandom_range(1, 6));
      random_phase(5'($urandom_range(1, 6)), inner,
                   ($urandom_range(3) == 0) ? 5'($urandom_range(1, 6)) : inner,
                   5'($urandom_range(1, 6)), 100, 6);
    end

    drain();
    repeat (20) @(negedge clk);
    $display("%0d items sent and %0d results checked over many size settings",
             n_in, n_out);
    $display("%0d inner mismatches and %0d range errors returned", n_mism, n_range);
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- matrix_multiply_row_col_sums.f -----
+incdir+rtl
rtl/mmrcs_pkg.sv
rtl/mmrcs_ram.sv
rtl/matrix_multiply_row_col_sums.sv
tb/tb_matrix_multiply_row_col_sums.sv
